[hw/rtl/pfp_pkg.sv]
// Shared types and constants for the page frame pool with LRU replacement.
// No dependencies.
package pfp_pkg;

  localparam int N_FRAMES_DEF  = 16;
  localparam int PAGE_W        = 32;
  localparam int PIN_W         = 16;
  localparam int STAMP_W       = 32;
  localparam int FIDX_W        = 4;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [PIN_W-1:0] PIN_MAX = '1;

  typedef enum logic [1:0] {
    CMD_FETCH = 2'd0,
    CMD_UNPIN = 2'd1,
    CMD_NEW   = 2'd2,
    CMD_FLUSH = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT        = 3'd0,
    ST_LOADED     = 3'd1,
    ST_CREATED    = 3'd2,
    ST_NO_FREE    = 3'd3,
    ST_UNPINNED   = 3'd4,
    ST_NOT_RES    = 3'd5,
    ST_FLUSHED    = 3'd6,
    ST_NONE_DIRTY = 3'd7
  } status_t;

  // Classified request handed from the front to the engine.
  typedef struct packed {
    cmd_t              op;
    logic [PAGE_W-1:0] key;
    logic              mark_dirty;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [FIDX_W-1:0] frame_index;
    logic [PAGE_W-1:0] result_page_id;
    logic              writeback_valid;
    logic [PAGE_W-1:0] writeback_page_id;
    logic              load_valid;
    logic              last;
  } res_t;

endpackage

[hw/rtl/pfp_if.sv]
// Valid/ready channel interfaces for the page frame pool.
// Depends on nothing; widths match the fields of pfp_pkg.
interface pfp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] page_id;
  logic        mark_dirty;
  logic [31:0] new_page_id;

  modport source (output valid, command, page_id, mark_dirty, new_page_id, input ready);
  modport sink   (input valid, command, page_id, mark_dirty, new_page_id, output ready);
endinterface

interface pfp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  frame_index;
  logic [31:0] result_page_id;
  logic        writeback_valid;
  logic [31:0] writeback_page_id;
  logic        load_valid;
  logic        last;

  modport source (output valid, status, frame_index, result_page_id, writeback_valid,
                  writeback_page_id, load_valid, last, input ready);
  modport sink   (input valid, status, frame_index, result_page_id, writeback_valid,
                  writeback_page_id, load_valid, last, output ready);
endinterface

[hw/rtl/pfp_front.sv]
// Front end: accepts items, classifies them into requests, two-entry queue.
// Depends on pfp_pkg and pfp_in_if.
module pfp_front (
  input  logic           clk,
  input  logic           rst_n,
  pfp_in_if.sink         in_ch,
  output logic           req_valid,
  output pfp_pkg::req_t  req,
  input  logic           req_pop
);

  pfp_pkg::req_t q_r [pfp_pkg::QUEUE_DEPTH];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    cnt_r;
  logic          push;
  pfp_pkg::req_t cls;

  // pick the key id by command
  always_comb begin
    cls.op         = pfp_pkg::cmd_t'(in_ch.command);
    cls.mark_dirty = in_ch.mark_dirty;
    cls.key        = (cls.op == pfp_pkg::CMD_NEW) ? in_ch.new_page_id : in_ch.page_id;
  end

  assign in_ch.ready = (cnt_r != 2'(pfp_pkg::QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign req_valid   = (cnt_r != 2'd0);
  assign req         = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        q_r[wr_ptr_r] <= cls;
        wr_ptr_r      <= ~wr_ptr_r;
      end
      if (req_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(req_pop);
    end
  end

endmodule

[hw/rtl/pfp_engine.sv]
// Back end: frame table, one-frame-per-cycle scan for lookup and victim choice,
// flush sweep, and the output register. Depends on pfp_pkg.
module pfp_engine #(
  parameter int N_FRAMES = pfp_pkg::N_FRAMES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_valid,
  input  pfp_pkg::req_t  req,
  output logic           req_pop,
  output logic           out_valid,
  output pfp_pkg::res_t  out_res,
  input  logic           out_ready
);

  localparam int IW = (N_FRAMES > 1) ? $clog2(N_FRAMES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] CNT_END  = CW'(N_FRAMES);
  localparam logic [IW-1:0] LAST_IDX = IW'(N_FRAMES - 1);
  localparam int PW = pfp_pkg::PAGE_W;
  localparam int NW = pfp_pkg::PIN_W;
  localparam int SW = pfp_pkg::STAMP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_EMIT, S_FL_SCAN, S_FL_GOT, S_FL_END
  } state_t;

  function automatic logic [pfp_pkg::FIDX_W-1:0] fidx(input logic [IW-1:0] i);
    logic [IW+pfp_pkg::FIDX_W-1:0] e;
    e = (IW + pfp_pkg::FIDX_W)'(i);
    return e[pfp_pkg::FIDX_W-1:0];
  endfunction

  // frame table storage
  logic [PW-1:0] page_mem  [N_FRAMES];
  logic [NW-1:0] pins_mem  [N_FRAMES];
  logic [SW-1:0] stamp_mem [N_FRAMES];
  logic [PW-1:0] rd_page;
  logic [NW-1:0] rd_pins;
  logic [SW-1:0] rd_stamp;

  logic [N_FRAMES-1:0] valid_r, dirty_r;
  logic [SW-1:0]        ctr_r;

  state_t        state_r;
  pfp_pkg::req_t req_r;
  logic [CW-1:0] cnt_r;
  logic [IW-1:0] ci, cidx_r;
  logic          cvld_r;

  logic          hit_vld_r;
  logic [IW-1:0] hit_idx_r;
  logic [NW-1:0] hit_pins_r;
  logic          best_vld_r, best_wb_r;
  logic [IW-1:0] best_idx_r;
  logic [SW-1:0] best_stamp_r;
  logic [PW-1:0] best_page_r;

  pfp_pkg::res_t res_r, res_nxt, ores_r, pend_r, emit_res;
  logic          ovld_r, pend_vld_r, can_push, ovld_set;

  // write port control
  logic          we_page, we_pins, we_stamp, set_valid, clr_dirty, set_dirty, stamp_inc;
  logic [IW-1:0] wa;
  logic [NW-1:0] wpins;

  // compare stage
  logic          c_valid, c_match, c_cand;
  logic [NW-1:0] c_pins;
  logic [SW-1:0] c_stamp;

  assign ci       = cnt_r[IW-1:0];
  assign can_push = !ovld_r || out_ready;
  assign req_pop  = (state_r == S_IDLE) && req_valid;
  assign out_valid = ovld_r;
  assign out_res   = ores_r;

  always_ff @(posedge clk) begin
    if (we_page)  page_mem[wa]  <= req_r.key;
    if (we_pins)  pins_mem[wa]  <= wpins;
    if (we_stamp) stamp_mem[wa] <= ctr_r;
    rd_page  <= page_mem[ci];
    rd_pins  <= pins_mem[ci];
    rd_stamp <= stamp_mem[ci];
  end

  // a frame never loaded reads as unpinned with stamp zero
  always_comb begin
    c_valid = valid_r[cidx_r];
    c_pins  = c_valid ? rd_pins  : '0;
    c_stamp = c_valid ? rd_stamp : '0;
    c_match = c_valid && (rd_page == req_r.key);
    c_cand  = (c_pins == '0) && (!best_vld_r || (c_stamp < best_stamp_r));
  end

  always_comb begin
    we_page   = 1'b0;
    we_pins   = 1'b0;
    we_stamp  = 1'b0;
    set_valid = 1'b0;
    clr_dirty = 1'b0;
    set_dirty = 1'b0;
    stamp_inc = 1'b0;
    wa        = hit_idx_r;
    wpins     = hit_pins_r;
    res_nxt   = '{status: pfp_pkg::ST_NOT_RES, frame_index: '0, result_page_id: req_r.key,
                  writeback_valid: 1'b0, writeback_page_id: '0, load_valid: 1'b0,
                  last: 1'b1};
    if (state_r == S_DECIDE) begin
      if (hit_vld_r && (req_r.op == pfp_pkg::CMD_FETCH)) begin
        we_pins   = 1'b1;
        we_stamp  = 1'b1;
        stamp_inc = 1'b1;
        wpins     = (hit_pins_r == pfp_pkg::PIN_MAX) ? hit_pins_r : hit_pins_r + NW'(1);
        res_nxt.status      = pfp_pkg::ST_HIT;
        res_nxt.frame_index = fidx(hit_idx_r);
      end else if (req_r.op == pfp_pkg::CMD_UNPIN) begin
        if (hit_vld_r) begin
          we_pins   = 1'b1;
          set_dirty = req_r.mark_dirty;
          wpins     = (hit_pins_r == '0) ? hit_pins_r : hit_pins_r - NW'(1);
          res_nxt.status      = pfp_pkg::ST_UNPINNED;
          res_nxt.frame_index = fidx(hit_idx_r);
        end
      end else if (!best_vld_r) begin
        res_nxt.status = pfp_pkg::ST_NO_FREE;
      end else begin
        // install into the victim frame
        wa        = best_idx_r;
        wpins     = NW'(1);
        we_page   = 1'b1;
        we_pins   = 1'b1;
        we_stamp  = 1'b1;
        stamp_inc = 1'b1;
        set_valid = 1'b1;
        clr_dirty = 1'b1;
        res_nxt.status            = (req_r.op == pfp_pkg::CMD_FETCH) ?
                                    pfp_pkg::ST_LOADED : pfp_pkg::ST_CREATED;
        res_nxt.frame_index       = fidx(best_idx_r);
        res_nxt.writeback_valid   = best_wb_r;
        res_nxt.writeback_page_id = best_wb_r ? best_page_r : '0;
        res_nxt.load_valid        = (req_r.op == pfp_pkg::CMD_FETCH);
      end
    end
  end

  // what goes into the output register this cycle
  always_comb begin
    ovld_set = 1'b0;
    emit_res = res_r;
    if (state_r == S_EMIT) begin
      ovld_set = can_push;
    end else if (state_r == S_FL_GOT) begin
      ovld_set = pend_vld_r && can_push;
      emit_res = pend_r;
    end else if (state_r == S_FL_END) begin
      ovld_set = can_push;
      if (pend_vld_r) begin
        emit_res = pend_r;
      end else begin
        emit_res = '{status: pfp_pkg::ST_NONE_DIRTY, frame_index: '0,
                     result_page_id: '0, writeback_valid: 1'b0,
                     writeback_page_id: '0, load_valid: 1'b0, last: 1'b1};
      end
      emit_res.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      valid_r    <= '0;
      dirty_r    <= '0;
      ctr_r      <= '0;
      ovld_r     <= 1'b0;
      pend_vld_r <= 1'b0;
      cvld_r     <= 1'b0;
      cnt_r      <= '0;
      hit_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      if (ovld_set) begin
        ovld_r <= 1'b1;
        ores_r <= emit_res;
      end else if (out_ready) begin
        ovld_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (req_valid) begin
            req_r      <= req;
            cnt_r      <= '0;
            cvld_r     <= 1'b0;
            hit_vld_r  <= 1'b0;
            best_vld_r <= 1'b0;
            pend_vld_r <= 1'b0;
            state_r    <= (req.op == pfp_pkg::CMD_FLUSH) ? S_FL_SCAN : S_SCAN;
          end
        end
        S_SCAN: begin
          if (cnt_r != CNT_END) cnt_r <= cnt_r + CW'(1);
          cvld_r <= (cnt_r != CNT_END);
          cidx_r <= ci;
          if (cvld_r) begin
            if (c_match && !hit_vld_r) begin
              hit_vld_r  <= 1'b1;
              hit_idx_r  <= cidx_r;
              hit_pins_r <= c_pins;
            end
            if (c_cand) begin
              best_vld_r   <= 1'b1;
              best_idx_r   <= cidx_r;
              best_stamp_r <= c_stamp;
              best_page_r  <= rd_page;
              best_wb_r    <= c_valid && dirty_r[cidx_r];
            end
            if (cidx_r == LAST_IDX) state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (set_valid) valid_r[wa] <= 1'b1;
          if (clr_dirty) dirty_r[wa] <= 1'b0;
          if (set_dirty) dirty_r[wa] <= 1'b1;
          if (stamp_inc) ctr_r <= ctr_r + SW'(1);
          res_r   <= res_nxt;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (can_push) state_r <= S_IDLE;
        end
        S_FL_SCAN: begin
          if (cnt_r == CNT_END) state_r <= S_FL_END;
          else if (valid_r[ci] && dirty_r[ci]) state_r <= S_FL_GOT;
          else cnt_r <= cnt_r + CW'(1);
        end
        S_FL_GOT: begin
          // hold one flushed result back so the final one can carry last
          if (!pend_vld_r || can_push) begin
            pend_vld_r  <= 1'b1;
            pend_r      <= '{status: pfp_pkg::ST_FLUSHED, frame_index: fidx(ci),
                             result_page_id: rd_page, writeback_valid: 1'b1,
                             writeback_page_id: rd_page, load_valid: 1'b0, last: 1'b0};
            dirty_r[ci] <= 1'b0;
            cnt_r       <= cnt_r + CW'(1);
            state_r     <= S_FL_SCAN;
          end
        end
        S_FL_END: begin
          if (can_push) begin
            pend_vld_r <= 1'b0;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_nofree_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && (ores_r.status == pfp_pkg::ST_NO_FREE) |->
      !ores_r.writeback_valid && !ores_r.load_valid)
    else $error("no-free result carries writeback or load");

  a_load_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    ovld_r && ores_r.load_valid |-> ores_r.status == pfp_pkg::ST_LOADED)
    else $error("load request on a non-load result");

  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) && stamp_inc |=> ctr_r == $past(ctr_r) + SW'(1))
    else $error("stamp counter did not advance by one");

  a_flush_target: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FL_GOT |-> valid_r[ci] && dirty_r[ci])
    else $error("flush emitting a clean or empty frame");

endmodule

[hw/rtl/page_frame_pool_lru.sv]
// Top level of the page frame pool with LRU replacement.
// Depends on pfp_pkg, pfp_if, pfp_front and pfp_engine.
//
// Usage:
//   in_ch (valid/ready) takes one command item: fetch, unpin, new page or flush.
//   out_ch (valid/ready) returns one result per fetch, unpin or new page, and
//   one result per dirty frame for a flush (last marks the final one; a flush
//   with nothing dirty returns a single "nothing dirty" result).
//   Items pass a two-entry request queue ahead of the frame engine, so the
//   input keeps taking items while the engine works or the output stalls.
// Operation:
//   fetch / unpin / new page: the engine scans one frame per cycle through
//   the frame memory read port, doing lookup and victim choice in the same
//   pass, then decides and registers the result.
//   flush: the sweep stops at each dirty frame to take its result.
//   The engine takes a new item only once the previous one is finished.
// Reset: synchronous, active low; all frames become empty, pins, stamps and
//   dirty marks read as zero at once (no clearing pass).
// Stall: a result waits in the output register; the engine holds until it
//   is taken, and the input stalls only once the request queue is full.
module page_frame_pool_lru #(
  parameter int N_FRAMES = pfp_pkg::N_FRAMES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  pfp_in_if.sink     in_ch,
  pfp_out_if.source  out_ch
);

  logic          req_valid, req_pop;
  pfp_pkg::req_t req;
  pfp_pkg::res_t res;

  pfp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  pfp_engine #(.N_FRAMES(N_FRAMES)) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop),
    .out_valid (out_ch.valid),
    .out_res   (res),
    .out_ready (out_ch.ready)
  );

  // result item onto the output channel
  assign out_ch.status            = res.status;
  assign out_ch.frame_index       = res.frame_index;
  assign out_ch.result_page_id    = res.result_page_id;
  assign out_ch.writeback_valid   = res.writeback_valid;
  assign out_ch.writeback_page_id = res.writeback_page_id;
  assign out_ch.load_valid        = res.load_valid;
  assign out_ch.last              = res.last;

endmodule

[dv/tb_page_frame_pool_lru.sv]
// Self-checking testbench for page_frame_pool_lru: fetch, unpin, new page and flush.
// A built-in frame table predictor checks every result item in order.
// Depends on pfp_pkg, pfp_if and the RTL of page_frame_pool_lru.
module tb_page_frame_pool_lru;

  localparam int NFR      = 16;
  localparam int WD_LIMIT = 4000;   // cycles with no item moving on either side

  logic clk;
  logic rst_n;

  pfp_in_if  in_ch();
  pfp_out_if out_ch();

  page_frame_pool_lru #(.N_FRAMES(NFR)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Frame table shadow.
  logic                      fr_valid [NFR];
  logic [31:0]               fr_page  [NFR];
  logic [pfp_pkg::PIN_W-1:0] fr_pins  [NFR];
  logic                      fr_dirty [NFR];
  logic [31:0]               fr_stamp [NFR];
  logic [31:0]               stamp_ctr;

  pfp_pkg::res_t pending_res_q[$];
  int            errors;
  int            stall_cycles;
  bit            no_idle;        // quiet stretch: neither side idles
  logic [31:0]   id_pool [24];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic pfp_pkg::res_t mk_res(pfp_pkg::status_t st, int fi, logic [31:0] pid,
                                           logic wbv, logic [31:0] wbid, logic ld,
                                           logic lst);
    pfp_pkg::res_t r;
    r.status            = st;
    r.frame_index       = fi[pfp_pkg::FIDX_W-1:0];
    r.result_page_id    = pid;
    r.writeback_valid   = wbv;
    r.writeback_page_id = wbid;
    r.load_valid        = ld;
    r.last              = lst;
    return r;
  endfunction

  function automatic int find_frame(logic [31:0] pid);
    for (int i = 0; i < NFR; i++)
      if (fr_valid[i] && fr_page[i] == pid) return i;
    return NFR;
  endfunction

  // Miss path shared by fetch and new page: oldest unpinned frame, lowest index on ties.
  function automatic void place_page(logic [31:0] pid, bit is_load);
    int v;
    logic wbv;
    logic [31:0] wbid;
    v = NFR;
    wbv = 1'b0;
    wbid = '0;
    for (int i = 0; i < NFR; i++)
      if (fr_pins[i] == 0 && (v == NFR || fr_stamp[i] < fr_stamp[v])) v = i;
    if (v == NFR) begin
      pending_res_q.push_back(mk_res(pfp_pkg::ST_NO_FREE, 0, pid, 1'b0, '0, 1'b0, 1'b1));
      return;
    end
    if (fr_valid[v] && fr_dirty[v]) begin
      wbv = 1'b1;
      wbid = fr_page[v];
    end
    fr_valid[v] = 1'b1;
    fr_page[v]  = pid;
    fr_dirty[v] = 1'b0;
    fr_pins[v]  = pfp_pkg::PIN_W'(1);
    fr_stamp[v] = stamp_ctr;
    stamp_ctr   = stamp_ctr + 32'd1;
    pending_res_q.push_back(mk_res(is_load ? pfp_pkg::ST_LOADED : pfp_pkg::ST_CREATED, v,
                                   pid, wbv, wbid, is_load, 1'b1));
  endfunction

  function automatic void predict_frame_table(pfp_pkg::cmd_t c, logic [31:0] pid, logic md,
                                              logic [31:0] npid);
    int i;
    int n;
    int m;
    case (c)
      pfp_pkg::CMD_FETCH: begin
        i = find_frame(pid);
        if (i < NFR) begin
          if (fr_pins[i] != pfp_pkg::PIN_MAX) fr_pins[i] = fr_pins[i] + pfp_pkg::PIN_W'(1);
          fr_stamp[i] = stamp_ctr;
          stamp_ctr   = stamp_ctr + 32'd1;
          pending_res_q.push_back(mk_res(pfp_pkg::ST_HIT, i, pid, 1'b0, '0, 1'b0, 1'b1));
        end else begin
          place_page(pid, 1'b1);
        end
      end
      pfp_pkg::CMD_UNPIN: begin
        i = find_frame(pid);
        if (i == NFR) begin
          pending_res_q.push_back(mk_res(pfp_pkg::ST_NOT_RES, 0, pid, 1'b0, '0, 1'b0,
                                         1'b1));
        end else begin
          if (fr_pins[i] != 0) fr_pins[i] = fr_pins[i] - pfp_pkg::PIN_W'(1);
          if (md) fr_dirty[i] = 1'b1;
          pending_res_q.push_back(mk_res(pfp_pkg::ST_UNPINNED, i, pid, 1'b0, '0, 1'b0,
                                         1'b1));
        end
      end
      pfp_pkg::CMD_NEW: place_page(npid, 1'b0);
      default: begin
        n = 0;
        m = 0;
        for (int k = 0; k < NFR; k++)
          if (fr_valid[k] && fr_dirty[k]) n++;
        if (n == 0) begin
          pending_res_q.push_back(mk_res(pfp_pkg::ST_NONE_DIRTY, 0, '0, 1'b0, '0, 1'b0,
                                         1'b1));
        end else begin
          for (int k = 0; k < NFR; k++)
            if (fr_valid[k] && fr_dirty[k]) begin
              m++;
              pending_res_q.push_back(mk_res(pfp_pkg::ST_FLUSHED, k, fr_page[k], 1'b1,
                                             fr_page[k], 1'b0, m == n));
              fr_dirty[k] = 1'b0;
            end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: valid stays high across back-to-back items, so it is only
  // lowered when an idle gap is inserted.
  // ---------------------------------------------------------------------------
  task automatic send_cmd(pfp_pkg::cmd_t c, logic [31:0] pid, logic md, logic [31:0] npid);
    bit rdy;
    while (!no_idle && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= c;
    in_ch.page_id     <= pid;
    in_ch.mark_dirty  <= md;
    in_ch.new_page_id <= npid;
    do begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
    end while (!rdy);
    predict_frame_table(c, pid, md, npid);
  endtask

  // Result side: random back-pressure, checked mid-cycle where signals are settled.
  always @(posedge clk) begin
    out_ch.ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);
  end

  always @(negedge clk) begin
    pfp_pkg::res_t want;
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (out_ch.valid && out_ch.ready) begin
        if (pending_res_q.size() == 0) begin
          $display("%0t: unexpected result item, status %0d page %h", $time,
                   out_ch.status, out_ch.result_page_id);
          errors++;
        end else begin
          want = pending_res_q.pop_front();
          if (out_ch.status !== want.status) begin
            $display("%0t: status exp %0d got %0d", $time, want.status, out_ch.status);
            errors++;
          end
          if (out_ch.frame_index !== want.frame_index) begin
            $display("%0t: frame_index exp %0d got %0d", $time, want.frame_index,
                     out_ch.frame_index);
            errors++;
          end
          if (out_ch.result_page_id !== want.result_page_id) begin
            $display("%0t: result_page_id exp %h got %h", $time, want.result_page_id,
                     out_ch.result_page_id);
            errors++;
          end
          if (out_ch.writeback_valid !== want.writeback_valid) begin
            $display("%0t: writeback_valid exp %0d got %0d", $time, want.writeback_valid,
                     out_ch.writeback_valid);
            errors++;
          end
          if (out_ch.writeback_page_id !== want.writeback_page_id) begin
            $display("%0t: writeback_page_id exp %h got %h", $time, want.writeback_page_id,
                     out_ch.writeback_page_id);
            errors++;
          end
          if (out_ch.load_valid !== want.load_valid) begin
            $display("%0t: load_valid exp %0d got %0d", $time, want.load_valid,
                     out_ch.load_valid);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $display("%0t: last exp %0d got %0d", $time, want.last, out_ch.last);
            errors++;
          end
        end
      end
      if (stall_cycles >= WD_LIMIT) begin
        $display("%0t: watchdog, nothing moved for %0d cycles", $time, WD_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_basic_ops();
    send_cmd(pfp_pkg::CMD_FLUSH, '0, 1'b0, '0);                 // nothing dirty, empty pool
    send_cmd(pfp_pkg::CMD_UNPIN, 32'hFFFF_FFFF, 1'b1, '0);      // not resident
    send_cmd(pfp_pkg::CMD_FETCH, 32'h0000_0000, 1'b0, '0);      // miss, load
    send_cmd(pfp_pkg::CMD_FETCH, 32'h0000_0000, 1'b0, 32'hFFFF_FFFF); // hit
    send_cmd(pfp_pkg::CMD_FETCH, 32'hFFFF_FFFF, 1'b1, '0);
    send_cmd(pfp_pkg::CMD_UNPIN, 32'h0000_0000, 1'b1, '0);
    send_cmd(pfp_pkg::CMD_UNPIN, 32'h0000_0000, 1'b0, '0);
    send_cmd(pfp_pkg::CMD_UNPIN, 32'h0000_0000, 1'b1, '0);      // pin floor, still dirties
    send_cmd(pfp_pkg::CMD_NEW, 32'h5555_5555, 1'b0, 32'hAAAA_AAAA);
    send_cmd(pfp_pkg::CMD_NEW, '0, 1'b0, 32'hFFFF_FFFF);        // duplicate resident id
    send_cmd(pfp_pkg::CMD_UNPIN, 32'hFFFF_FFFF, 1'b1, '0);      // lowest matching frame
    send_cmd(pfp_pkg::CMD_FLUSH, 32'h1234_5678, 1'b1, 32'h8765_4321);
    send_cmd(pfp_pkg::CMD_FLUSH, '0, 1'b0, '0);
  endtask

  // Pin every frame, then ask for more; afterwards release the pages and evict one.
  task automatic test_pool_full();
    for (int i = 0; i < NFR; i++) send_cmd(pfp_pkg::CMD_FETCH, 32'h100 + i, 1'b0, '0);
    send_cmd(pfp_pkg::CMD_FETCH, 32'hDEAD_BEEF, 1'b0, '0);
    send_cmd(pfp_pkg::CMD_NEW, '0, 1'b0, 32'hCAFE_F00D);
    for (int i = 0; i < NFR; i++) send_cmd(pfp_pkg::CMD_UNPIN, 32'h100 + i, i[0], '0);
    send_cmd(pfp_pkg::CMD_FETCH, 32'hDEAD_BEEF, 1'b0, '0);      // evicts the oldest released page
    send_cmd(pfp_pkg::CMD_UNPIN, 32'hDEAD_BEEF, 1'b1, '0);
  endtask

  task automatic test_random_mix();
    logic [31:0] pid;
    int sel;
    for (int i = 0; i < 24; i++) id_pool[i] = $urandom;
    id_pool[0] = '0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int n = 0; n < 150; n++) begin
      no_idle = (n >= 50 && n < 90);
      pid = id_pool[$urandom_range(23)];
      if ($urandom_range(19) == 0) pid = $urandom;
      sel = $urandom_range(99);
      if (sel < 38)
        send_cmd(pfp_pkg::CMD_FETCH, pid, 1'($urandom_range(1)), $urandom);
      else if (sel < 80)
        send_cmd(pfp_pkg::CMD_UNPIN, pid, 1'($urandom_range(1)), $urandom);
      else if (sel < 92)
        send_cmd(pfp_pkg::CMD_NEW, $urandom, 1'($urandom_range(1)), pid);
      else
        send_cmd(pfp_pkg::CMD_FLUSH, $urandom, 1'($urandom_range(1)), $urandom);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    errors       = 0;
    stall_cycles = 0;
    no_idle      = 1'b0;
    stamp_ctr    = '0;
    for (int i = 0; i < NFR; i++) begin
      fr_valid[i] = 1'b0;
      fr_page[i]  = '0;
      fr_pins[i]  = '0;
      fr_dirty[i] = 1'b0;
      fr_stamp[i] = '0;
    end
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= pfp_pkg::CMD_FETCH;
    in_ch.page_id      <= '0;
    in_ch.mark_dirty   <= 1'b0;
    in_ch.new_page_id  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_basic_ops();
    test_pool_full();
    test_random_mix();
    in_ch.valid <= 1'b0;

    while (pending_res_q.size() != 0) @(posedge clk);
    repeat (4 * NFR) @(posedge clk);
    if (errors == 0 && pending_res_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
